### sv/vds_pkg.sv
// ============================================================================
// vds_pkg
// Shared types and constants for the 2x2x2 box-filter volume downsampler.
// ============================================================================
package vds_pkg;

    // Field widths fixed by the stream and configuration formats
    localparam int VOXEL_W    = 8;
    localparam int SUM_W      = 11;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Smallest legal source dimension
    localparam int MIN_DIM = 2;

    // log2 of the voxel count of one cell
    localparam int CELL_SHIFT = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_SRC_DEPTH  = 2'd2
    } cfg_reg_t;

    // Per-voxel control carried from the address stage to the update stage
    typedef struct packed {
        logic active;   // voxel lies inside a full cell
        logic first;    // first voxel of its cell: start a new sum
        logic emit;     // last voxel of its cell: produce a result
        logic last;     // last cell of the volume
    } cell_ctl_t;

endpackage

### sv/vds_ram.sv
// ============================================================================
// vds_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module vds_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16384
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/voxel_downsample_2x_box.sv
// A cell's last voxel sits in the update stage, then its mean in the output register.
// Throughput: 1 voxel per cycle; each voxel in a full cell does one read-modify-write
// of a partial sum in the plane RAM (read in the address stage, write-back in the update
// stage). The input stalls only while a finished result waits in the output register.
// Reset: positions and control clear, all three dimensions return to 2; the sum RAM is
// not cleared, since the first voxel of every cell overwrites its entry.
// ============================================================================
// voxel_downsample_2x_box
// Streams source voxels in raster order, accumulates 2x2x2 cell sums in a
// plane-wide RAM and emits each cell mean in destination raster order.
// ============================================================================
module voxel_downsample_2x_box #(
    parameter int MAX_SRC_DIM = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vds_pkg::CFG_DATA_W-1:0]  cfg_data,

    // Source voxel stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [vds_pkg::VOXEL_W-1:0]     s_axis_tdata,   // [7:0] voxel

    // Destination voxel stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [vds_pkg::VOXEL_W-1:0]     m_axis_tdata,   // [7:0] average
    output logic                            m_axis_tlast    // last_voxel
);

    import vds_pkg::*;

    localparam int HALF_DIM  = MAX_SRC_DIM / 2;
    localparam int SUM_DEPTH = HALF_DIM * HALF_DIM;
    localparam int AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int DIM_W     = $clog2(MAX_SRC_DIM + 1);
    localparam int PW        = $clog2(MAX_SRC_DIM);
    localparam int CMP_W     = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   width_reg, height_reg, depth_reg;
    logic [PW-1:0]      pos_x_reg, pos_y_reg, pos_z_reg;
    logic [PW-1:0]      pos_x_next, pos_y_next, pos_z_next;
    logic [AW-1:0]      row_base_reg, row_base_next;

    logic               s1_valid_reg;
    logic [VOXEL_W-1:0] s1_voxel_reg;
    logic [AW-1:0]      s1_idx_reg;
    cell_ctl_t          s1_ctl_reg;

    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_idx_reg;
    logic [SUM_W-1:0]   fwd_sum_reg;

    logic               out_valid_reg;
    logic [VOXEL_W-1:0] out_avg_reg;
    logic               out_last_reg;

    logic               in_xfer;
    logic               cfg_xfer;
    logic               s1_adv;
    logic               sum_we;
    logic [DIM_W-1:0]   cfg_dim;
    logic [DIM_W-1:0]   width_even, height_even, depth_even;
    logic [DIM_W-1:0]   pos_x_ext, pos_y_ext, pos_z_ext;
    logic               x_wrap, y_wrap, z_wrap;
    logic [AW-1:0]      rd_idx;
    cell_ctl_t          ctl;
    logic [SUM_W-1:0]   ram_rdata;
    logic [SUM_W-1:0]   prev_sum;
    logic [SUM_W-1:0]   s1_sum;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign cfg_ready     = 1'b1;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s1_adv        = s1_valid_reg && (!s1_ctl_reg.emit || !s1_ctl_reg.active ||
                                            !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_avg_reg;
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Clamp a written dimension into its legal range
    // ------------------------------------------------------------------
    always_comb
    begin
        if (CMP_W'(cfg_data) < CMP_W'(MIN_DIM))
        begin
            cfg_dim = DIM_W'(MIN_DIM);
        end
        else if (CMP_W'(cfg_data) > CMP_W'(MAX_SRC_DIM))
        begin
            cfg_dim = DIM_W'(MAX_SRC_DIM);
        end
        else
        begin
            cfg_dim = DIM_W'(cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Address stage: cell index, cell flags and next raster position
    // ------------------------------------------------------------------
    assign width_even  = {width_reg[DIM_W-1:1], 1'b0};
    assign height_even = {height_reg[DIM_W-1:1], 1'b0};
    assign depth_even  = {depth_reg[DIM_W-1:1], 1'b0};
    assign pos_x_ext   = DIM_W'(pos_x_reg);
    assign pos_y_ext   = DIM_W'(pos_y_reg);
    assign pos_z_ext   = DIM_W'(pos_z_reg);

    assign x_wrap = (pos_x_ext == width_reg - DIM_W'(1));
    assign y_wrap = (pos_y_ext == height_reg - DIM_W'(1));
    assign z_wrap = (pos_z_ext == depth_reg - DIM_W'(1));

    assign rd_idx = row_base_reg + AW'(pos_x_reg >> 1);

    always_comb
    begin
        ctl.active = (pos_x_ext < width_even) && (pos_y_ext < height_even) &&
                     (pos_z_ext < depth_even);
        ctl.first  = !pos_x_reg[0] && !pos_y_reg[0] && !pos_z_reg[0];
        ctl.emit   = pos_x_reg[0] && pos_y_reg[0] && pos_z_reg[0];
        ctl.last   = (pos_x_ext == width_even - DIM_W'(1)) &&
                     (pos_y_ext == height_even - DIM_W'(1)) &&
                     (pos_z_ext == depth_even - DIM_W'(1));
    end

    // Advance x, then y, then z; step the row base after each odd row
    always_comb
    begin
        pos_x_next    = pos_x_reg + PW'(1);
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        row_base_next = row_base_reg;
        if (x_wrap)
        begin
            pos_x_next = '0;
            if (y_wrap)
            begin
                pos_y_next    = '0;
                row_base_next = '0;
                pos_z_next    = z_wrap ? '0 : pos_z_reg + PW'(1);
            end
            else
            begin
                pos_y_next = pos_y_reg + PW'(1);
                if (pos_y_reg[0])
                begin
                    row_base_next = row_base_reg + AW'(width_reg >> 1);
                end
            end
        end
    end

    // Dimension registers and raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DIM_W'(MIN_DIM);
            height_reg   <= DIM_W'(MIN_DIM);
            depth_reg    <= DIM_W'(MIN_DIM);
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            row_base_reg <= '0;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:
                begin
                    width_reg    <= cfg_dim;
                    pos_x_reg    <= '0;
                    pos_y_reg    <= '0;
                    pos_z_reg    <= '0;
                    row_base_reg <= '0;
                end
                REG_SRC_HEIGHT:
                begin
                    height_reg   <= cfg_dim;
                    pos_x_reg    <= '0;
                    pos_y_reg    <= '0;
                    pos_z_reg    <= '0;
                    row_base_reg <= '0;
                end
                REG_SRC_DEPTH:
                begin
                    depth_reg    <= cfg_dim;
                    pos_x_reg    <= '0;
                    pos_y_reg    <= '0;
                    pos_z_reg    <= '0;
                    row_base_reg <= '0;
                end
                default:
                begin
                    // Unmapped index: drop the write
                end
            endcase
        end
        else if (in_xfer)
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            row_base_reg <= row_base_next;
        end
    end

    // ------------------------------------------------------------------
    // Partial-sum RAM: read on transfer, write back from the update stage
    // ------------------------------------------------------------------
    assign sum_we = s1_adv && s1_ctl_reg.active;

    vds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (s1_idx_reg),
        .wdata (s1_sum),
        .re    (in_xfer),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Update stage: forward the last write-back, accumulate
    // ------------------------------------------------------------------
    assign prev_sum = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_sum_reg
                                                                      : ram_rdata;
    assign s1_sum   = s1_ctl_reg.first ? SUM_W'(s1_voxel_reg)
                                       : prev_sum + SUM_W'(s1_voxel_reg);

    // Update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (sum_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Update stage payload and forwarding register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_voxel_reg <= s_axis_tdata;
            s1_idx_reg   <= rd_idx;
            s1_ctl_reg   <= ctl;
        end
        if (sum_we)
        begin
            fwd_idx_reg <= s1_idx_reg;
            fwd_sum_reg <= s1_sum;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold a result until the downstream transfer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sum_we && s1_ctl_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_we && s1_ctl_reg.emit)
        begin
            out_avg_reg  <= VOXEL_W'(s1_sum >> CELL_SHIFT);
            out_last_reg <= s1_ctl_reg.last;
        end
    end

endmodule

### sv/vds_check.sv
// ============================================================================
// vds_check
// Port-level checks for the voxel downsampler, bound to its top level.
// ============================================================================
module vds_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [vds_pkg::VOXEL_W-1:0]  m_axis_tdata,
    input  logic                         m_axis_tlast
);

    import vds_pkg::*;

    logic [VOXEL_W-1:0] tdata_seen;

    assign tdata_seen = m_axis_tdata;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(tdata_seen) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A result is withdrawn only by a transfer
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without transfer");

    // Input backpressure comes only from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A new result follows an input transfer that passed through the update stage
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a source voxel");

endmodule

bind voxel_downsample_2x_box vds_check u_vds_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
